FILE: rtl/core/gtl_pkg.sv
// Shared types and constants of the glyph text layout unit.
`timescale 1ns / 1ps

package gtl_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_ADDR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_WIDTH = 3'd6;

  localparam int unsigned CFG_DATA_W = 32;

  // Glyph record size in bytes: width * ceil(height/8) + 1, at most 4081.
  localparam int unsigned REC_W = 12;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] char_code;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic        one_line;
    logic        cut_off;
    logic        transparent;
    logic        pixel_color;
    logic [7:0]  table_index;
    logic [7:0]  table_width;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [15:0] glyph_address;
    logic [7:0]  glyph_width;
    logic        draw_transparent;
    logic        draw_color;
  } out_word_t;

  typedef struct packed {
    logic [31:0] first_char;
    logic [31:0] last_char;
    logic [7:0]  font_width;
    logic [6:0]  font_height;
    logic [15:0] font_base;
    logic [15:0] undef_addr;
    logic [7:0]  undef_width;
  } cfg_t;

  typedef struct packed {
    logic one_line;
    logic cut_off;
    logic transparent;
    logic pixel_color;
  } str_flags_t;

  // Word handed from the glyph lookup to the cursor placement stage.
  typedef struct packed {
    logic        is_start;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    str_flags_t  flags;
    logic [15:0] glyph_address;
    logic [7:0]  glyph_width;
  } place_item_t;

endpackage

FILE: rtl/core/gtl_ram.sv
// Generic one-write, one-read RAM with registered read data.
`timescale 1ns / 1ps

module gtl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/gtl_lookup.sv
// Glyph lookup: input register, width table and glyph address computation.
`timescale 1ns / 1ps

module gtl_lookup
  import gtl_pkg::*;
#(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  input  cfg_t              cfg,
  input  logic [REC_W-1:0]  rec_size,
  input  logic              place_ready,
  output logic              s2_valid,
  output place_item_t       s2_item
);

  localparam int unsigned IW   = $clog2(GLYPH_COUNT);
  localparam int unsigned PW   = IW + REC_W;

  logic              en1, en2, accept;
  logic [31:0]       diff;
  logic              hit;
  logic              load_we;
  logic [7:0]        ram_q;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_start_r, s1_start_nxt;
  logic              s1_hit_r, s1_hit_nxt;
  logic [IW-1:0]     s1_idx_r, s1_idx_nxt;
  logic [7:0]        s1_sx_r, s1_sx_nxt;
  logic [7:0]        s1_sy_r, s1_sy_nxt;
  str_flags_t        s1_flags_r, s1_flags_nxt;

  logic              s2_v_r, s2_v_nxt;
  place_item_t       s2_item_r, s2_item_nxt;

  logic [PW-1:0]     prod;

  assign en2      = !s2_v_r || place_ready;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  // Glyph index and range check on the incoming code.
  assign diff = in_word.char_code - cfg.first_char;
  assign hit  = (in_word.char_code >= cfg.first_char) &&
                (in_word.char_code <= cfg.last_char) &&
                (diff < 32'(GLYPH_COUNT));

  assign load_we = accept && (in_word.command == CMD_LOAD) &&
                   ({24'd0, in_word.table_index} < 32'(GLYPH_COUNT));

  gtl_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_COUNT)
  ) u_width_table (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (IW'(in_word.table_index)),
    .wr_data (in_word.table_width),
    .rd_en   (accept && (in_word.command == CMD_CHAR)),
    .rd_addr (diff[IW-1:0]),
    .rd_data (ram_q)
  );

  always_comb begin
    s1_v_nxt     = s1_v_r;
    s1_start_nxt = s1_start_r;
    s1_hit_nxt   = s1_hit_r;
    s1_idx_nxt   = s1_idx_r;
    s1_sx_nxt    = s1_sx_r;
    s1_sy_nxt    = s1_sy_r;
    s1_flags_nxt = s1_flags_r;
    if (en1) begin
      s1_v_nxt     = accept && ((in_word.command == CMD_START) ||
                                (in_word.command == CMD_CHAR));
      s1_start_nxt = (in_word.command == CMD_START);
      s1_hit_nxt   = hit;
      s1_idx_nxt   = diff[IW-1:0];
      s1_sx_nxt    = in_word.start_x;
      s1_sy_nxt    = in_word.start_y;
      s1_flags_nxt = '{one_line:    in_word.one_line,
                       cut_off:     in_word.cut_off,
                       transparent: in_word.transparent,
                       pixel_color: in_word.pixel_color};
    end
  end

  assign prod = PW'(s1_idx_r) * PW'(rec_size);

  always_comb begin
    s2_v_nxt    = s2_v_r;
    s2_item_nxt = s2_item_r;
    if (en2) begin
      s2_v_nxt             = s1_v_r;
      s2_item_nxt.is_start = s1_start_r;
      s2_item_nxt.start_x  = s1_sx_r;
      s2_item_nxt.start_y  = s1_sy_r;
      s2_item_nxt.flags    = s1_flags_r;
      if (s1_hit_r) begin
        s2_item_nxt.glyph_address = cfg.font_base + prod[15:0] + 16'd1;
        s2_item_nxt.glyph_width   = ram_q;
      end else begin
        s2_item_nxt.glyph_address = cfg.undef_addr + 16'd1;
        s2_item_nxt.glyph_width   = cfg.undef_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
    s1_start_r <= s1_start_nxt;
    s1_hit_r   <= s1_hit_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s1_sx_r    <= s1_sx_nxt;
    s1_sy_r    <= s1_sy_nxt;
    s1_flags_r <= s1_flags_nxt;
    s2_item_r  <= s2_item_nxt;
  end

  assign s2_valid = s2_v_r;
  assign s2_item  = s2_item_r;

endmodule

FILE: rtl/core/gtl_place.sv
// Cursor placement: edge wrapping, abort state and the result register.
`timescale 1ns / 1ps

module gtl_place
  import gtl_pkg::*;
#(
  parameter int unsigned X_LIMIT = 128,
  parameter int unsigned Y_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s2_valid,
  input  place_item_t s2_item,
  input  cfg_t        cfg,
  output logic        place_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  logic [7:0]  cur_x_r, cur_x_nxt;
  logic [7:0]  cur_y_r, cur_y_nxt;
  logic        aborted_r, aborted_nxt;
  str_flags_t  flags_r, flags_nxt;
  logic        out_v_r, out_v_nxt;
  out_word_t   out_r, out_nxt;

  logic        en_o, go;
  logic [8:0]  x_sum, y_sum;
  logic [7:0]  x1, y1;
  logic        err;

  assign en_o        = !out_v_r || !out_stall;
  assign go          = s2_valid && en_o;
  assign place_ready = en_o;

  assign x_sum = {1'b0, cur_x_r} + {1'b0, s2_item.glyph_width};

  // Wrap in X first; the Y check sees the row after any X wrap.
  always_comb begin
    err = 1'b0;
    x1  = cur_x_r;
    y1  = cur_y_r;
    if (x_sum > 9'(X_LIMIT)) begin
      if (flags_r.cut_off) begin
        err = 1'b1;
      end else begin
        x1 = 8'd0;
        if (!flags_r.one_line) begin
          y1 = cur_y_r + {1'b0, cfg.font_height};
        end
      end
    end
    y_sum = {1'b0, y1} + {2'b0, cfg.font_height};
    if (!err && (y_sum > 9'(Y_LIMIT))) begin
      if (flags_r.cut_off || flags_r.one_line) begin
        err = 1'b1;
      end else begin
        y1 = 8'd0;
      end
    end
  end

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    aborted_nxt = aborted_r;
    flags_nxt   = flags_r;
    out_v_nxt   = out_v_r;
    out_nxt     = out_r;
    if (en_o) begin
      out_v_nxt = s2_valid && !s2_item.is_start && !aborted_r;
    end
    if (go) begin
      if (s2_item.is_start) begin
        cur_x_nxt   = s2_item.start_x;
        cur_y_nxt   = s2_item.start_y;
        flags_nxt   = s2_item.flags;
        aborted_nxt = 1'b0;
      end else if (!aborted_r) begin
        if (err) begin
          aborted_nxt = 1'b1;
          out_nxt     = '0;
          out_nxt.status = 1'b1;
        end else begin
          cur_x_nxt = x1 + s2_item.glyph_width;
          cur_y_nxt = y1;
          out_nxt.status           = 1'b0;
          out_nxt.draw_x           = x1;
          out_nxt.draw_y           = y1;
          out_nxt.glyph_address    = s2_item.glyph_address;
          out_nxt.glyph_width      = s2_item.glyph_width;
          out_nxt.draw_transparent = flags_r.transparent;
          out_nxt.draw_color       = flags_r.pixel_color;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= 8'd0;
      cur_y_r   <= 8'd0;
      aborted_r <= 1'b0;
      flags_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      aborted_r <= aborted_nxt;
      flags_r   <= flags_nxt;
      out_v_r   <= out_v_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule

FILE: rtl/core/glyph_text_layout_unit.sv
// Top level of the glyph text layout unit: configuration registers and pipeline.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Word
//  in_       input      in_valid / in_stall  in_word_t: load, start or character
//  out_      output     out_valid/out_stall  out_word_t: draw command or error
//  cfg_      input      cfg_valid/cfg_ready  cfg_index selects, cfg_data writes
//
// The unit takes one input word in every cycle without in_stall. A character
// word passes the input, lookup and placement stages on its way to out_: the
// input stage reads the width table RAM, the lookup stage does the record
// multiply and address add, and the placement stage wraps the cursor and
// loads the output register. Reset (rst_n low, synchronous) clears the
// cursor, string flags, abort flag and all valid bits and restores the
// register defaults; the width table holds garbage until loaded. A stall on
// out_ fills the empty stages first and only then raises in_stall.

module glyph_text_layout_unit
  import gtl_pkg::*;
#(
  parameter int unsigned GLYPH_COUNT = 256,
  parameter int unsigned X_LIMIT     = 128,
  parameter int unsigned Y_LIMIT     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg_r, cfg_nxt;
  logic [REC_W-1:0]  rec_r, rec_nxt;
  logic [7:0]        row_sum;
  logic [4:0]        rows;
  logic              place_ready;
  logic              s2_valid;
  place_item_t       s2_item;

  // Configuration is taken in any cycle; the host must write only while the
  // pipeline is empty, and the unit itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_CHAR:  cfg_nxt.first_char  = cfg_data;
        CFG_LAST_CHAR:   cfg_nxt.last_char   = cfg_data;
        CFG_FONT_WIDTH:  cfg_nxt.font_width  = cfg_data[7:0];
        CFG_FONT_HEIGHT: cfg_nxt.font_height = cfg_data[6:0];
        CFG_FONT_BASE:   cfg_nxt.font_base   = cfg_data[15:0];
        CFG_UNDEF_ADDR:  cfg_nxt.undef_addr  = cfg_data[15:0];
        CFG_UNDEF_WIDTH: cfg_nxt.undef_width = cfg_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // Record size per glyph: one byte per column for each group of eight rows,
  // plus a leading width byte. Registered so the lookup stage sees one
  // multiply only; it is loaded from the configuration registers.
  assign row_sum = {1'b0, cfg_r.font_height} + 8'd7;
  assign rows    = row_sum[7:3];
  assign rec_nxt = REC_W'(13'(cfg_r.font_width) * 13'(rows)) + REC_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_char  <= 32'd32;
      cfg_r.last_char   <= 32'd126;
      cfg_r.font_width  <= 8'd5;
      cfg_r.font_height <= 7'd8;
      cfg_r.font_base   <= 16'd0;
      cfg_r.undef_addr  <= 16'd0;
      cfg_r.undef_width <= 8'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
    rec_r <= rec_nxt;
  end

  gtl_lookup #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .cfg         (cfg_r),
    .rec_size    (rec_r),
    .place_ready (place_ready),
    .s2_valid    (s2_valid),
    .s2_item     (s2_item)
  );

  gtl_place #(
    .X_LIMIT (X_LIMIT),
    .Y_LIMIT (Y_LIMIT)
  ) u_place (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2_item     (s2_item),
    .cfg         (cfg_r),
    .place_ready (place_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

FILE: tb/tb_glyph_text_layout_unit.sv
// Self-checking testbench of the glyph text layout unit with a built-in layout predictor.
`timescale 1ns / 1ps

// The bench drives load, start and character words into the unit, predicts
// every draw command or edge error in software, and compares each word that
// leaves the unit with the oldest prediction, field by field. Both channels
// idle and stall at random. The font registers are changed only while the
// unit is drained.

module tb_glyph_text_layout_unit;
  import gtl_pkg::*;

  localparam int unsigned GLYPH_COUNT = 256;
  localparam int unsigned X_LIMIT     = 128;
  localparam int unsigned Y_LIMIT     = 64;

  // Command code the unit ignores and register index that holds nothing.
  localparam logic [1:0]           CMD_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // The pipeline is three stages deep, so SETTLE_CYCLES more cover any word
  // that is still on its way but produces no output.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  glyph_text_layout_unit #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .X_LIMIT    (X_LIMIT),
    .Y_LIMIT    (Y_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: font registers, cursor, string flags and width table.
  cfg_t        font_cfg;
  logic [7:0]  cur_x;
  logic [7:0]  cur_y;
  logic        string_dead;
  str_flags_t  cur_flags;
  logic [7:0]  glyph_widths [GLYPH_COUNT];

  out_word_t   pending_draws [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // When set, the sender or the receiver runs a stretch without any idling.
  logic quiet_in  = 1'b0;
  logic quiet_out = 1'b0;

  // Software copy of the layout step. It is called once per accepted word and
  // queues any draw command or edge error that the word must produce.
  function automatic void place_glyph(input in_word_t w);
    logic [31:0] delta;
    int unsigned rec, addr, wid, x, y, fh;
    logic        err;
    out_word_t   d;
    case (w.command)
      CMD_LOAD: begin
        if (w.table_index < GLYPH_COUNT) glyph_widths[w.table_index] = w.table_width;
      end
      CMD_START: begin
        cur_x                 = w.start_x;
        cur_y                 = w.start_y;
        cur_flags.one_line    = w.one_line;
        cur_flags.cut_off     = w.cut_off;
        cur_flags.transparent = w.transparent;
        cur_flags.pixel_color = w.pixel_color;
        string_dead           = 1'b0;
      end
      CMD_CHAR: begin
        if (!string_dead) begin
          fh    = font_cfg.font_height;
          delta = w.char_code - font_cfg.first_char;
          // A code outside the font, or past the end of the width table, is
          // drawn with the undefined glyph.
          if (w.char_code >= font_cfg.first_char && w.char_code <= font_cfg.last_char &&
              delta < GLYPH_COUNT) begin
            rec  = font_cfg.font_width * ((fh + 7) >> 3) + 1;
            addr = (font_cfg.font_base + delta * rec + 1) & 16'hFFFF;
            wid  = glyph_widths[delta[7:0]];
          end else begin
            addr = (font_cfg.undef_addr + 1) & 16'hFFFF;
            wid  = font_cfg.undef_width;
          end
          x   = cur_x;
          y   = cur_y;
          err = 1'b0;
          // Right edge: abort the string, or go to the line start, one line down unless in one-line mode.
          if (x + wid > X_LIMIT) begin
            if (cur_flags.cut_off) begin
              err = 1'b1;
            end else begin
              x = 0;
              if (!cur_flags.one_line) y = (y + fh) & 8'hFF;
            end
          end
          // Bottom edge: abort in cut-off or one-line mode, else wrap to the top.
          if (!err && y + fh > Y_LIMIT) begin
            if (cur_flags.cut_off || cur_flags.one_line) err = 1'b1;
            else y = 0;
          end
          d = '0;
          if (err) begin
            d.status    = 1'b1;
            string_dead = 1'b1;
          end else begin
            d.draw_x           = x[7:0];
            d.draw_y           = y[7:0];
            d.glyph_address    = addr[15:0];
            d.glyph_width      = wid[7:0];
            d.draw_transparent = cur_flags.transparent;
            d.draw_color       = cur_flags.pixel_color;
            cur_x              = 8'((x + wid) & 8'hFF);
            cur_y              = y[7:0];
          end
          pending_draws.push_back(d);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Every word leaving the unit is matched against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        $error("output word %h arrived while nothing was expected", out_word);
        mismatches++;
      end else begin
        want = pending_draws.pop_front();
        check_field("status", want.status, out_word.status);
        check_field("draw_x", want.draw_x, out_word.draw_x);
        check_field("draw_y", want.draw_y, out_word.draw_y);
        check_field("glyph_address", want.glyph_address, out_word.glyph_address);
        check_field("glyph_width", want.glyph_width, out_word.glyph_width);
        check_field("draw_transparent", want.draw_transparent, out_word.draw_transparent);
        check_field("draw_color", want.draw_color, out_word.draw_color);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Lengths of idle gaps and stalls: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 1);
    if (r < 90) return $urandom_range(2, 7);
    return $urandom_range(15, 40);
  endfunction

  // Receiver back-pressure: alternating runs of flow and stall.
  int unsigned stall_hold = 0;
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (quiet_out || out_stall) begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b1;
      stall_hold = stall_len();
    end
  end

  function automatic in_word_t rand_word();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  // Word builders: fields that the command does not use carry random junk.
  function automatic in_word_t load_word(input logic [7:0] idx, input logic [7:0] wid);
    in_word_t w;
    w             = rand_word();
    w.command     = CMD_LOAD;
    w.table_index = idx;
    w.table_width = wid;
    return w;
  endfunction

  function automatic in_word_t start_word(input logic [7:0] x, input logic [7:0] y,
                                          input logic ol, input logic co,
                                          input logic tr, input logic pc);
    in_word_t w;
    w             = rand_word();
    w.command     = CMD_START;
    w.start_x     = x;
    w.start_y     = y;
    w.one_line    = ol;
    w.cut_off     = co;
    w.transparent = tr;
    w.pixel_color = pc;
    return w;
  endfunction

  function automatic in_word_t char_word(input logic [31:0] code);
    in_word_t w;
    w           = rand_word();
    w.command   = CMD_CHAR;
    w.char_code = code;
    return w;
  endfunction

  function automatic in_word_t idle_cmd_word();
    in_word_t w;
    w         = rand_word();
    w.command = CMD_NONE;
    return w;
  endfunction

  // Sends one word and waits until the unit takes it. Called at a falling
  // edge and returns at a falling edge with in_valid still high, so a word
  // that follows without a gap keeps valid up.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = quiet_in ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_word  <= rand_word();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    place_glyph(w);
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted word has come back, then a
  // little longer for words that produce no output.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FIRST_CHAR:  font_cfg.first_char  = data;
      CFG_LAST_CHAR:   font_cfg.last_char   = data;
      CFG_FONT_WIDTH:  font_cfg.font_width  = data[7:0];
      CFG_FONT_HEIGHT: font_cfg.font_height = data[6:0];
      CFG_FONT_BASE:   font_cfg.font_base   = data[15:0];
      CFG_UNDEF_ADDR:  font_cfg.undef_addr  = data[15:0];
      CFG_UNDEF_WIDTH: font_cfg.undef_width = data[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Rewrites the whole font description. Bits above each register's width
  // carry junk, which the unit must drop.
  task automatic set_font(input logic [31:0] first, input logic [31:0] last,
                          input logic [7:0] fw, input logic [6:0] fh,
                          input logic [15:0] base, input logic [15:0] uaddr,
                          input logic [7:0] uwid);
    wait_drained();
    write_reg(CFG_FIRST_CHAR, first);
    write_reg(CFG_LAST_CHAR, last);
    write_reg(CFG_FONT_WIDTH, {24'($urandom_range(0, 24'hFFFFFF)), fw});
    write_reg(CFG_FONT_HEIGHT, {25'($urandom_range(0, 25'h1FFFFFF)), fh});
    write_reg(CFG_FONT_BASE, {16'($urandom_range(0, 16'hFFFF)), base});
    write_reg(CFG_UNDEF_ADDR, {16'($urandom_range(0, 16'hFFFF)), uaddr});
    write_reg(CFG_UNDEF_WIDTH, {24'($urandom_range(0, 24'hFFFFFF)), uwid});
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_width();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(0, 12)) : 8'($urandom);
  endfunction

  // Character codes: mostly inside the font or just past its ends, some
  // anywhere in the 32-bit space.
  function automatic logic [31:0] pick_code();
    int unsigned r;
    logic [31:0] span;
    r = $urandom_range(99);
    if (font_cfg.last_char >= font_cfg.first_char) begin
      span = font_cfg.last_char - font_cfg.first_char;
      if (span > 258) span = 258;
      span = span + 2;
    end else begin
      span = 4;
    end
    if (r < 75) return font_cfg.first_char + $urandom_range(0, span);
    if (r < 82) return font_cfg.first_char - 1;
    if (r < 88) return font_cfg.last_char + 1;
    return $urandom;
  endfunction

  function automatic in_word_t rand_start();
    logic [7:0] x, y;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) x = 8'($urandom);
    else if (r < 65) x = 8'($urandom_range(100, 128));
    else x = 8'($urandom_range(0, 40));
    r = $urandom_range(99);
    if (r < 50) y = 8'($urandom_range(0, 63));
    else if (r < 70) y = 8'($urandom_range(48, 63));
    else y = 8'($urandom);
    return start_word(x, y, $urandom_range(99) < 40, $urandom_range(99) < 30,
                      1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // Every table entry gets a width before the first character, so no
  // character ever reads an entry that was never loaded.
  task automatic test_load_width_table();
    for (int i = 0; i < GLYPH_COUNT; i++) begin
      send_word(load_word(i[7:0], (i >= 200) ? 8'($urandom) : 8'($urandom_range(1, 10))));
    end
  endtask

  // Hand-picked cases on the reset font (codes 32..126, 5x8 records).
  task automatic test_directed_cases();
    send_word(load_word(8'd0, 8'd8));
    send_word(load_word(8'd255, 8'd255));
    send_word(load_word(8'd2, 8'd0));
    // A character before any start uses the reset cursor and flags.
    send_word(char_word(32'd32));
    send_word(idle_cmd_word());
    // Last code, one below and one above the font, the top code.
    send_word(start_word(8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_word(char_word(32'd126));
    send_word(char_word(32'd31));
    send_word(char_word(32'd127));
    send_word(char_word(32'hFFFF_FFFF));
    // Right edge moves to the next line, or stays on it in one-line mode.
    send_word(start_word(8'd125, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(char_word(32'd32));
    send_word(start_word(8'd127, 8'd8, 1'b1, 1'b0, 1'b1, 1'b0));
    send_word(char_word(32'd32));
    // Right edge in cut-off mode aborts; the next character is dropped.
    send_word(start_word(8'd127, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(char_word(32'd32));
    send_word(char_word(32'd32));
    // Bottom edge wraps to the top, or aborts in one-line mode.
    send_word(start_word(8'd0, 8'd60, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(char_word(32'd33));
    send_word(start_word(8'd0, 8'd60, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(char_word(32'd33));
    // Largest cursor, then a zero-width glyph right at the edge.
    send_word(start_word(8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0));
    send_word(char_word(32'd33));
    send_word(start_word(8'd128, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_word(char_word(32'd34));
  endtask

  // Mostly well-formed strings with random content, plus broken starts and
  // stray words.
  task automatic test_random_strings(input int unsigned n_words);
    int unsigned sent, len, r, k;
    sent = 0;
    while (sent < n_words) begin
      quiet_in  = ($urandom_range(7) == 0);
      quiet_out = ($urandom_range(7) == 0);
      r = $urandom_range(99);
      if (r < 85) begin
        send_word(rand_start());
        sent++;
        len = $urandom_range(1, 24);
        repeat (len) begin
          k = $urandom_range(99);
          if (k < 6) begin
            send_word(load_word(8'($urandom), rand_width()));
            sent++;
          end else if (k < 9) begin
            send_word(idle_cmd_word());
          end else begin
            send_word(char_word(pick_code()));
            sent++;
          end
        end
      end else if (r < 93) begin
        // A start that is replaced before any character.
        send_word(rand_start());
        send_word(rand_start());
        send_word(char_word(pick_code()));
        sent += 3;
      end else begin
        send_word(idle_cmd_word());
        send_word(load_word(8'($urandom), rand_width()));
        send_word(char_word(pick_code()));
        sent += 2;
      end
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  task automatic test_widest_font();
    set_font(32'd0, 32'hFFFF_FFFF, 8'd255, 7'd64, 16'hFFFF, 16'hFFFF, 8'd255);
    test_random_strings(300);
  endtask

  task automatic test_narrowest_font();
    set_font(32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'd1, 7'd1, 16'h0000, 16'h0000, 8'd0);
    test_random_strings(300);
  endtask

  // Last code below the first: every character falls back to the undefined glyph.
  task automatic test_empty_font();
    set_font(32'd200, 32'd100, 8'd7, 7'd12, 16'($urandom), 16'($urandom), rand_width());
    test_random_strings(150);
  endtask

  task automatic test_random_fonts();
    logic [31:0] first;
    repeat (2) begin
      first = ($urandom_range(1) != 0) ? 32'($urandom_range(0, 300)) : $urandom;
      set_font(first, first + $urandom_range(0, 400), 8'($urandom_range(1, 255)),
               7'($urandom_range(1, 64)), 16'($urandom), 16'($urandom), rand_width());
      test_random_strings(300);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    font_cfg  = '{first_char: 32'd32, last_char: 32'd126, font_width: 8'd5,
                  font_height: 7'd8, font_base: 16'd0, undef_addr: 16'd0,
                  undef_width: 8'd5};
    cur_x       = '0;
    cur_y       = '0;
    string_dead = 1'b0;
    cur_flags   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_load_width_table();
    test_directed_cases();
    test_random_strings(330);
    test_widest_font();
    test_narrowest_font();
    test_empty_font();
    test_random_fonts();

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/gtl_pkg.sv
rtl/core/gtl_ram.sv
rtl/core/gtl_lookup.sv
rtl/core/gtl_place.sv
rtl/core/glyph_text_layout_unit.sv
tb/tb_glyph_text_layout_unit.sv
